/* hdl/ffa_pkg.sv */
// shared types and constants of the first-fit frame allocator
package ffa_pkg;

  localparam int CMD_W       = 1;
  localparam int SLOT_W      = 4;
  localparam int REQ_BYTES_W = 19;
  localparam int STATUS_W    = 2;
  localparam int BASE_W      = 18;
  localparam int GRANT_W     = 19;
  localparam int FREE_W      = 7;

  localparam int FB_W        = 13;
  localparam int FIU_W       = 7;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 13;

  localparam logic [FB_W-1:0]  FB_RESET  = 13'd16;
  localparam logic [FIU_W-1:0] FIU_RESET = 7'd64;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_BYTES   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAMES_IN_USE = 1'b1;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 1'b1;

  // rounded-up numerator is request plus frame size minus one
  localparam int NUM_W  = 20;
  localparam int STEP_W = $clog2(NUM_W);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(NUM_W - 1);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_NO_SLOT  = 2'd2
  } ffa_status_t;

  typedef enum logic [1:0] {
    SWEEP_NONE,
    SWEEP_MARK,
    SWEEP_FREE
  } ffa_sweep_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_DIVIDE,
    S_SCAN,
    S_SWEEP,
    S_FINISH
  } ffa_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]       command;
    logic [SLOT_W-1:0]      owner_slot;
    logic [REQ_BYTES_W-1:0] request_bytes;
  } ffa_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BASE_W-1:0]   base_address;
    logic [GRANT_W-1:0]  granted_bytes;
    logic [FREE_W-1:0]   free_frames;
  } ffa_rsp_t;

  typedef struct packed {
    logic        clear_step;
    logic        load_req;
    logic        div_start;
    logic        scan_init;
    logic        scan_step;
    logic        sweep_init;
    ffa_sweep_t  sweep_kind;
    ffa_status_t sweep_status;
    logic        sweep_step;
    logic        finish;
  } ffa_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic slot_ok;
    logic is_release;
    logic slot_held;
    logic div_done;
    logic need_ok;
    logic scan_found;
    logic scan_end;
    logic sweep_end;
    logic out_free;
  } ffa_stat_t;

endpackage

/* hdl/ffa_div.sv */
// restoring divider, one quotient bit per cycle
module ffa_div import ffa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [FB_W-1:0]  den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);

  logic [FB_W-1:0]   rem;
  logic [FB_W-1:0]   den_r;
  logic [STEP_W-1:0] step;
  logic [FB_W:0]     shifted;
  logic [FB_W:0]     diff;
  logic              fits;

  assign shifted = {rem, quo[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      step  <= '0;
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (busy) begin
      rem  <= fits ? diff[FB_W-1:0] : shifted[FB_W-1:0];
      quo  <= {quo[NUM_W-2:0], fits};
      step <= step + STEP_W'(1);
      if (step == DIV_LAST) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

/* hdl/ffa_ctrl.sv */
// sequencing state machine of the frame allocator
module ffa_ctrl import ffa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  ffa_stat_t stat,
  output ffa_cmd_t  cmd
);

  ffa_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        if (stat.slot_ok && !stat.is_release) state_next = S_DIVIDE;
        else state_next = S_SWEEP;
      end
      S_DIVIDE: begin
        if (stat.div_done) state_next = stat.need_ok ? S_SCAN : S_SWEEP;
      end
      S_SCAN: begin
        if (stat.scan_found || stat.scan_end) state_next = S_SWEEP;
      end
      S_SWEEP: begin
        if (stat.sweep_end) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd              = '0;
    cmd.sweep_kind   = SWEEP_NONE;
    cmd.sweep_status = ST_OK;
    req_ready        = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      S_IDLE: begin
        req_ready    = 1'b1;
        cmd.load_req = req_valid;
      end
      S_LOOKUP: begin
        if (!stat.slot_ok) begin
          cmd.sweep_init   = 1'b1;
          cmd.sweep_status = ST_NO_SLOT;
        end else if (stat.is_release) begin
          cmd.sweep_init = 1'b1;
          if (stat.slot_held) begin
            cmd.sweep_kind = SWEEP_FREE;
          end else begin
            cmd.sweep_status = ST_NO_SLOT;
          end
        end else begin
          cmd.div_start = 1'b1;
        end
      end
      S_DIVIDE: begin
        if (stat.div_done) begin
          if (stat.need_ok) begin
            cmd.scan_init = 1'b1;
          end else begin
            cmd.sweep_init   = 1'b1;
            cmd.sweep_status = ST_NO_SPACE;
          end
        end
      end
      S_SCAN: begin
        if (stat.scan_found) begin
          cmd.sweep_init = 1'b1;
          cmd.sweep_kind = SWEEP_MARK;
        end else if (stat.scan_end) begin
          cmd.sweep_init   = 1'b1;
          cmd.sweep_status = ST_NO_SPACE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SWEEP: begin
        cmd.sweep_step = !stat.sweep_end;
      end
      S_FINISH: begin
        cmd.finish = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

/* hdl/ffa_datapath.sv */
// bitmap memory, slot table, scan and sweep counters, result register
module ffa_datapath import ffa_pkg::*; #(
  parameter int MAX_FRAMES = 64,
  parameter int SLOT_COUNT = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ffa_req_t               req,
  output ffa_rsp_t               rsp,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  ffa_cmd_t               cmd,
  output ffa_stat_t              stat
);

  localparam int FW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int NW  = $clog2(MAX_FRAMES + 1);
  localparam int HW  = NW + 1;
  localparam int SW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int BPW = FW + FB_W;
  localparam int GPW = NW + FB_W;

  // configuration
  logic [FB_W-1:0]  frame_bytes;
  logic [FIU_W-1:0] frames_in_use;
  logic [FB_W-1:0]  fb_eff;
  logic [NW-1:0]    managed;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bytes   <= FB_RESET;
      frames_in_use <= FIU_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_BYTES:   frame_bytes   <= cfg_data[FB_W-1:0];
        REG_FRAMES_IN_USE: frames_in_use <= cfg_data[FIU_W-1:0];
        default: ;
      endcase
    end
  end

  assign fb_eff  = (frame_bytes == '0) ? FB_W'(1) : frame_bytes;
  assign managed = (32'(frames_in_use) > MAX_FRAMES) ? NW'(MAX_FRAMES) : NW'(frames_in_use);

  // request held for the whole transaction
  logic [CMD_W-1:0]       cmd_r;
  logic [SLOT_W-1:0]      slot_r;
  logic [REQ_BYTES_W-1:0] bytes_r;
  logic [SW-1:0]          slot_idx;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      cmd_r   <= req.command;
      slot_r  <= req.owner_slot;
      bytes_r <= req.request_bytes;
    end
  end

  assign slot_idx = SW'(slot_r);

  // frames needed, rounded up
  logic [NUM_W-1:0] div_num;
  logic [NUM_W-1:0] need;
  logic [NW-1:0]    need_t;
  logic             div_busy;

  assign div_num = NUM_W'(bytes_r) + NUM_W'(fb_eff) - NUM_W'(1);
  assign need_t  = NW'(need);

  ffa_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (fb_eff),
    .busy  (div_busy),
    .quo   (need)
  );

  // slot table
  logic [SLOT_COUNT-1:0] slot_vld;
  logic [FW-1:0]         start_mem [SLOT_COUNT];
  logic [NW-1:0]         count_mem [SLOT_COUNT];
  logic [FW-1:0]         start_rd;
  logic [NW-1:0]         count_rd;
  logic [FW-1:0]         run_start;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      start_rd <= start_mem[SW'(req.owner_slot)];
      count_rd <= count_mem[SW'(req.owner_slot)];
    end
    if (cmd.sweep_init && cmd.sweep_kind == SWEEP_MARK) begin
      start_mem[slot_idx] <= run_start;
      count_mem[slot_idx] <= need_t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= '0;
    end else if (cmd.sweep_init) begin
      case (cmd.sweep_kind)
        SWEEP_MARK: slot_vld[slot_idx] <= 1'b1;
        SWEEP_FREE: slot_vld[slot_idx] <= 1'b0;
        default: ;
      endcase
    end
  end

  // bitmap memory and its clearing pass
  logic          used_mem [MAX_FRAMES];
  logic          rd_data;
  logic          rd_en;
  logic [FW-1:0] rd_addr;
  logic [NW-1:0] clr_idx;
  logic          clear_done;
  logic          clr_we;
  logic          sw_we;
  logic          nbit;

  logic [NW-1:0] sc_idx;
  logic          sc_pend;
  logic [FW-1:0] sc_pidx;
  logic [NW-1:0] run;
  logic [NW-1:0] run_inc;
  logic          found;

  logic [NW-1:0] sw_idx;
  logic          sw_pend;
  logic [FW-1:0] sw_pidx;
  logic [NW-1:0] sw_pidx_n;
  logic [NW-1:0] lo;
  logic [NW-1:0] hi;
  logic [NW-1:0] limit;
  logic          sw_mark;
  logic [NW-1:0] cnt;
  logic          in_range;

  assign clear_done = (clr_idx == NW'(MAX_FRAMES));
  assign clr_we     = cmd.clear_step && !clear_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (clr_we) begin
      clr_idx <= clr_idx + NW'(1);
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = FW'(sc_idx);
    if (cmd.scan_step && sc_idx < managed) begin
      rd_en = 1'b1;
    end else if (cmd.sweep_step && sw_idx < limit) begin
      rd_en   = 1'b1;
      rd_addr = FW'(sw_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (clr_we) begin
      used_mem[clr_idx[FW-1:0]] <= 1'b0;
    end else if (sw_we) begin
      used_mem[sw_pidx] <= nbit;
    end
    if (rd_en) begin
      rd_data <= used_mem[rd_addr];
    end
  end

  // first-fit scan, one frame per cycle behind the registered read
  assign run_inc = run + NW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_idx  <= '0;
      sc_pend <= 1'b0;
      found   <= 1'b0;
      run     <= '0;
    end else if (cmd.scan_init) begin
      sc_idx  <= '0;
      sc_pend <= 1'b0;
      found   <= 1'b0;
      run     <= '0;
    end else if (cmd.scan_step) begin
      if (sc_idx < managed) begin
        sc_pend <= 1'b1;
        sc_pidx <= FW'(sc_idx);
        sc_idx  <= sc_idx + NW'(1);
      end else begin
        sc_pend <= 1'b0;
      end
      if (sc_pend && !found) begin
        if (!rd_data) begin
          if (run == '0) run_start <= sc_pidx;
          run <= run_inc;
          if (run_inc >= need_t) found <= 1'b1;
        end else begin
          run <= '0;
        end
      end
    end
  end

  // plan of the sweep: range to mark or free, and the reported region
  logic [HW-1:0] plan_hi_w;
  logic [NW-1:0] plan_lo;
  logic [NW-1:0] plan_hi;
  logic [NW-1:0] plan_limit;
  logic [FW-1:0] plan_start;
  logic [NW-1:0] plan_count;

  always_comb begin
    case (cmd.sweep_kind)
      SWEEP_MARK: begin
        plan_start = run_start;
        plan_count = need_t;
      end
      SWEEP_FREE: begin
        plan_start = start_rd;
        plan_count = count_rd;
      end
      default: begin
        plan_start = '0;
        plan_count = '0;
      end
    endcase
    plan_lo    = NW'(plan_start);
    plan_hi_w  = HW'(plan_start) + HW'(plan_count);
    plan_hi    = (32'(plan_hi_w) > MAX_FRAMES) ? NW'(MAX_FRAMES) : NW'(plan_hi_w);
    plan_limit = (plan_hi > managed) ? plan_hi : managed;
  end

  // sweep: applies the range and recounts free managed frames
  assign sw_pidx_n = NW'(sw_pidx);
  assign in_range  = (sw_pidx_n >= lo) && (sw_pidx_n < hi);
  assign nbit      = sw_mark ? (rd_data | in_range) : (rd_data & ~in_range);
  assign sw_we     = cmd.sweep_step && sw_pend && in_range;

  ffa_status_t   res_status;
  logic [FW-1:0] res_start;
  logic [NW-1:0] res_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      sw_idx  <= '0;
      sw_pend <= 1'b0;
      limit   <= '0;
      cnt     <= '0;
    end else if (cmd.sweep_init) begin
      sw_idx     <= '0;
      sw_pend    <= 1'b0;
      cnt        <= '0;
      lo         <= plan_lo;
      hi         <= plan_hi;
      limit      <= plan_limit;
      sw_mark    <= (cmd.sweep_kind == SWEEP_MARK);
      res_status <= cmd.sweep_status;
      res_start  <= plan_start;
      res_count  <= plan_count;
    end else if (cmd.sweep_step) begin
      if (sw_idx < limit) begin
        sw_pend <= 1'b1;
        sw_pidx <= FW'(sw_idx);
        sw_idx  <= sw_idx + NW'(1);
      end else begin
        sw_pend <= 1'b0;
      end
      if (sw_pend && sw_pidx_n < managed && !nbit) begin
        cnt <= cnt + NW'(1);
      end
    end
  end

  // result register
  logic [BPW-1:0] base_prod;
  logic [GPW-1:0] grant_prod;
  logic           out_free;

  assign base_prod  = BPW'(res_start) * BPW'(fb_eff);
  assign grant_prod = GPW'(res_count) * GPW'(fb_eff);
  assign out_free   = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.status        <= res_status;
      rsp.base_address  <= BASE_W'(base_prod);
      rsp.granted_bytes <= GRANT_W'(grant_prod);
      rsp.free_frames   <= FREE_W'(cnt);
    end
  end

  always_comb begin
    stat            = '0;
    stat.clear_done = clear_done;
    stat.slot_ok    = (32'(slot_r) < SLOT_COUNT);
    stat.is_release = (cmd_r == CMD_RELEASE);
    stat.slot_held  = slot_vld[slot_idx];
    stat.div_done   = !div_busy;
    stat.need_ok    = (need != '0) && (need <= NUM_W'(managed));
    stat.scan_found = found;
    stat.scan_end   = (sc_idx == managed) && !sc_pend && !found;
    stat.sweep_end  = (sw_idx == limit) && !sw_pend;
    stat.out_free   = out_free;
  end

endmodule

/* hdl/first_fit_frame_allocator.sv */
// top level of the first-fit contiguous frame allocator
//
//  channel  signals                          direction  carries
//  req      req_valid req_ready req         in         command, owner slot, byte size
//  rsp      rsp_valid rsp_ready rsp         out        status, address, size, free count
//  cfg      cfg_valid cfg_ready cfg_index   in         frame size, managed frame count
//           cfg_data
//
// one request at a time, n managed frames. allocate: accept the request and look up the slot,
// divide, scan to the first run that fits, sweep over the bitmap ram to mark the run and
// recount free frames, then load the result. zero-size or oversize allocate skips the scan;
// release skips division and scan and sweeps up to the larger of n and the end of the freed
// region. reset clears the ram first. a result waiting in the output register stalls only the
// finish of the next transaction.
module first_fit_frame_allocator import ffa_pkg::*; #(
  parameter int MAX_FRAMES = 64,
  parameter int SLOT_COUNT = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  ffa_req_t               req,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output ffa_rsp_t               rsp,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  ffa_cmd_t  cmd;
  ffa_stat_t stat;

  // configuration writes are always accepted and registered
  assign cfg_ready = 1'b1;

  ffa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ffa_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
